@@ design/unit_vector_to_spherical_unit_defines.svh @@
// Assertion macros for the unit vector to spherical unit
`ifndef UNIT_VECTOR_TO_SPHERICAL_UNIT_DEFINES_SVH
`define UNIT_VECTOR_TO_SPHERICAL_UNIT_DEFINES_SVH
// Clocked assertion with active-low reset disable
`define UVS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assertion that also holds during reset
`define UVS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ design/uvs_pkg.sv @@
// Shared types, constants and tables for the unit vector to spherical unit
package uvs_pkg;
  localparam int TableLen = 24;
  localparam int IntBits = 34;
  typedef logic signed [IntBits-1:0] q31_t;
  typedef logic [31:0] turn_t;
  typedef logic [1:0] axis_t;
  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;
  localparam turn_t HalfTurn = 32'h8000_0000;
  localparam logic [31:0] KinvQ32 = 32'd2608131496;

  function automatic turn_t atan_turn(input int idx);
    turn_t t;
    case (idx)
      0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
      3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
      6: t = 32'd10679838;   7: t = 32'd5340245;    8: t = 32'd2670163;
      9: t = 32'd1335087;    10: t = 32'd667544;    11: t = 32'd333772;
      12: t = 32'd166886;    13: t = 32'd83443;     14: t = 32'd41722;
      15: t = 32'd20861;     16: t = 32'd10430;     17: t = 32'd5215;
      18: t = 32'd2608;      19: t = 32'd1304;      20: t = 32'd652;
      21: t = 32'd326;       22: t = 32'd163;       23: t = 32'd81;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [15:0] q31_to_q15(input q31_t v);
    logic signed [IntBits:0] r;
    logic signed [IntBits:0] q;
    logic [15:0] o;
    r = IntBits'(v) + (IntBits+1)'(32768);
    q = r >>> 16;
    if (q > 32767) o = 16'h7fff;
    else if (q < -32768) o = 16'h8000;
    else o = q[15:0];
    return o;
  endfunction
endpackage

@@ design/uvs_if.sv @@
// Valid/ready channel interfaces for input vectors and results
interface uvs_in_if #(parameter int COORD_BITS = 16) (input logic clk);
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] coord_x;
  logic signed [COORD_BITS-1:0] coord_y;
  logic signed [COORD_BITS-1:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

interface uvs_out_if (input logic clk);
  logic valid;
  logic ready;
  logic [15:0] polar_angle;
  logic [15:0] azimuth_angle;
  logic signed [15:0] polar_cosine;
  logic [14:0] polar_sine;
  logic signed [15:0] azimuth_cos_scaled;
  logic signed [15:0] azimuth_sin_scaled;
  modport source (output valid, polar_angle, azimuth_angle, polar_cosine, polar_sine,
                  azimuth_cos_scaled, azimuth_sin_scaled, input ready);
  modport sink (input valid, polar_angle, azimuth_angle, polar_cosine, polar_sine,
                azimuth_cos_scaled, azimuth_sin_scaled, output ready);
endinterface

@@ design/unit_vector_to_spherical_unit.sv @@
// Top level: unit vector to polar/azimuth angles via pipelined CORDIC
//  channel | dir | handshake         | payload
//  in_     | in  | valid/ready       | coord_x, coord_y, coord_z
//  out_    | out | valid/ready       | angles, cosine, sine, scaled pair
//  cfg_    | in  | write enable only | pole_axis
// One vector per cycle unless the output stalls; root first, then the CORDICs.
// Whole pipeline advances together; a stalled output holds every stage.
// Synchronous active-low reset clears valid bits and sets pole axis to Z.
`include "unit_vector_to_spherical_unit_defines.svh"
module unit_vector_to_spherical_unit import uvs_pkg::*; #(
  parameter int CORDIC_STAGES = 16,
  parameter int COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  uvs_in_if.sink      in_ch,
  uvs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);
  localparam int NS = (CORDIC_STAGES < TableLen) ? CORDIC_STAGES : TableLen;
  localparam int DEPTH = 1 + 32 + NS + 1 + NS + 1;
  axis_t pole_r;
  logic  adv;
  logic [DEPTH-1:0] vld_r;
  assign adv = out_ch.ready || !vld_r[DEPTH-1];
  assign in_ch.ready = adv;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pole_r <= AXIS_Z;
      vld_r <= '0;
    end else begin
      if (cfg_we) pole_r <= cfg_wdata;
      if (adv) vld_r <= {vld_r[DEPTH-2:0], in_ch.valid};
    end
  end

  function automatic q31_t load(input logic [COORD_BITS-1:0] raw);
    logic signed [63:0] v;
    v = 64'(signed'(raw));
    if (COORD_BITS <= 32) v = v <<< (32 - COORD_BITS);
    return IntBits'(v);
  endfunction

  // Stage 0: select and clamp
  q31_t c0, a0, b0, c_r, a_r, b_r;
  always_comb begin
    case (pole_r)
      AXIS_X: begin c0 = load(in_ch.coord_x); a0 = load(in_ch.coord_z); b0 = load(in_ch.coord_y); end
      AXIS_Y: begin c0 = load(in_ch.coord_y); a0 = load(in_ch.coord_x); b0 = load(in_ch.coord_z); end
      default: begin c0 = load(in_ch.coord_z); a0 = load(in_ch.coord_y); b0 = load(in_ch.coord_x); end
    endcase
    if (c0 > q31_t'(34'sd2147483648)) c0 = q31_t'(34'sd2147483648);
    if (c0 < -q31_t'(34'sd2147483648)) c0 = -q31_t'(34'sd2147483648);
  end
  logic [62:0] rad_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c0; a_r <= a0; b_r <= b0;
      rad_r <= 63'((64'd1 << 62) - (64'(c0) * 64'(c0)));
    end
  end

  // Root pipeline with delayed side data
  logic [31:0] s_root;
  uvs_isqrt u_sqrt (.clk(clk), .en(adv), .rad(rad_r), .root(s_root));
  q31_t cd [0:32], ad [0:32], bd [0:32];
  assign cd[0] = c_r; assign ad[0] = a_r; assign bd[0] = b_r;
  for (genvar k = 0; k < 32; k++) begin : g_dl
    always_ff @(posedge clk) if (adv) begin
      cd[k+1] <= cd[k]; ad[k+1] <= ad[k]; bd[k+1] <= bd[k];
    end
  end

  // Vectoring CORDICs for polar (s,c) and azimuth (a,b)
  q31_t px [0:NS], py [0:NS], ax [0:NS], ay [0:NS];
  turn_t pang [0:NS], aang [0:NS];
  q31_t cv [0:NS];
  logic [31:0] sv [0:NS];
  logic zz [0:NS];
  always_comb begin
    px[0] = cd[32]; py[0] = q31_t'({2'b00, s_root}); pang[0] = '0;
    if (cd[32] < 0) begin px[0] = -cd[32]; py[0] = -py[0]; pang[0] = HalfTurn; end
    ax[0] = bd[32]; ay[0] = ad[32]; aang[0] = '0;
    if (bd[32] < 0) begin ax[0] = -bd[32]; ay[0] = -ad[32]; aang[0] = HalfTurn; end
    zz[0] = (ad[32] == 0) && (bd[32] == 0);
    cv[0] = cd[32]; sv[0] = s_root;
  end
  for (genvar i = 0; i < NS; i++) begin : g_vec
    always_ff @(posedge clk) if (adv) begin
      if (py[i] >= 0) begin
        px[i+1] <= px[i] + (py[i] >>> i); py[i+1] <= py[i] - (px[i] >>> i);
        pang[i+1] <= pang[i] + atan_turn(i);
      end else begin
        px[i+1] <= px[i] - (py[i] >>> i); py[i+1] <= py[i] + (px[i] >>> i);
        pang[i+1] <= pang[i] - atan_turn(i);
      end
      if (ay[i] >= 0) begin
        ax[i+1] <= ax[i] + (ay[i] >>> i); ay[i+1] <= ay[i] - (ax[i] >>> i);
        aang[i+1] <= aang[i] + atan_turn(i);
      end else begin
        ax[i+1] <= ax[i] - (ay[i] >>> i); ay[i+1] <= ay[i] + (ax[i] >>> i);
        aang[i+1] <= aang[i] - atan_turn(i);
      end
      zz[i+1] <= zz[i]; cv[i+1] <= cv[i]; sv[i+1] <= sv[i];
    end
  end

  // Angle fixup and rotation setup
  turn_t polar_r, azim_r;
  q31_t rx [0:NS], ry [0:NS];
  logic signed [33:0] rz [0:NS];
  q31_t cr [0:NS];
  logic [31:0] sr [0:NS];
  turn_t pr [0:NS], zr [0:NS];
  logic [63:0] sk;
  turn_t az_n, pol_n;
  logic signed [33:0] z0;
  q31_t x0;
  always_comb begin
    pol_n = pang[NS];
    if (pol_n > 32'hC000_0000) pol_n = '0;
    else if (pol_n > HalfTurn) pol_n = HalfTurn;
    az_n = zz[NS] ? '0 : aang[NS];
    sk = 64'(sv[NS]) * 64'(KinvQ32);
    x0 = q31_t'(sk[63:32]);
    z0 = 34'(signed'(az_n));
    if (z0 > 34'sd1073741824) begin z0 = z0 - 34'sd2147483648; x0 = -x0; end
    else if (z0 < -34'sd1073741824) begin z0 = z0 + 34'sd2147483648; x0 = -x0; end
  end
  always_ff @(posedge clk) if (adv) begin
    rx[0] <= x0; ry[0] <= '0; rz[0] <= z0;
    cr[0] <= cv[NS]; sr[0] <= sv[NS]; pr[0] <= pol_n; zr[0] <= az_n;
  end
  for (genvar i = 0; i < NS; i++) begin : g_rot
    always_ff @(posedge clk) if (adv) begin
      if (rz[i] >= 0) begin
        rx[i+1] <= rx[i] - (ry[i] >>> i); ry[i+1] <= ry[i] + (rx[i] >>> i);
        rz[i+1] <= rz[i] - 34'(atan_turn(i));
      end else begin
        rx[i+1] <= rx[i] + (ry[i] >>> i); ry[i+1] <= ry[i] - (rx[i] >>> i);
        rz[i+1] <= rz[i] + 34'(atan_turn(i));
      end
      cr[i+1] <= cr[i]; sr[i+1] <= sr[i]; pr[i+1] <= pr[i]; zr[i+1] <= zr[i];
    end
  end

  // Output register
  logic [32:0] sp;
  turn_t azr;
  assign sp = (33'(sr[NS]) + 33'd32768) >> 16;
  assign azr = zr[NS] + 32'h8000;
  always_ff @(posedge clk) if (adv) begin
    out_ch.polar_angle <= 16'((33'(pr[NS]) + 33'h8000) >> 16);
    out_ch.azimuth_angle <= azr[31:16];
    out_ch.polar_cosine <= q31_to_q15(cr[NS]);
    out_ch.polar_sine <= (sp > 33'd32767) ? 15'h7fff : sp[14:0];
    out_ch.azimuth_cos_scaled <= q31_to_q15(rx[NS]);
    out_ch.azimuth_sin_scaled <= q31_to_q15(ry[NS]);
  end
  assign out_ch.valid = vld_r[DEPTH-1];

  `UVS_ASSERT(a_hold, clk, rst_n, out_ch.valid && !out_ch.ready |=> out_ch.valid, "result dropped")
  `UVS_ASSERT(a_ready, clk, rst_n, !out_ch.valid |-> in_ch.ready, "stall without result")
  `UVS_ASSERT(a_pol, clk, rst_n, out_ch.valid |-> out_ch.polar_angle <= 16'd32768, "polar range")
  `UVS_ASSERT_ALWAYS(a_rst, clk, !rst_n |=> !out_ch.valid, "valid after reset")
endmodule

@@ design/uvs_isqrt.sv @@
// Pipelined integer square root, one result bit per stage
module uvs_isqrt import uvs_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] rad,
  output logic [31:0] root
);
  // Stage k decides root bit 31-k by squaring a trial value and comparing it with the radicand
  logic [62:0] rem_r [0:32];
  logic [31:0] res_r [0:32];
  logic [62:0] rad_d [0:32];
  assign rem_r[0] = rad;
  assign res_r[0] = '0;
  for (genvar k = 0; k <= 32; k++) begin : g_rd
    assign rad_d[k] = rem_r[k];
  end
  for (genvar k = 0; k < 32; k++) begin : g_st
    localparam int B = 31 - k;
    logic [63:0] trial;
    logic [31:0] cand;
    always_comb begin
      cand = res_r[k] | (32'd1 << B);
      trial = 64'(cand) * 64'(cand);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (trial <= 64'(rad_d[k])) res_r[k+1] <= cand;
        else res_r[k+1] <= res_r[k];
        rem_r[k+1] <= rem_r[k];
      end
    end
  end
  assign root = res_r[32];
endmodule
